@@ rtl/core/tcgr_pkg.sv @@
package tcgr_pkg;

  localparam int FONT_CHARS     = 256;
  localparam int MAX_GLYPH_ROWS = 32;
  localparam int GLYPH_WIDTH    = 8;
  localparam int STORE_DEPTH    = FONT_CHARS * MAX_GLYPH_ROWS;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);
  localparam int CURSOR_W       = 10;
  localparam int CURSOR_LIMIT   = 1 << CURSOR_W;
  localparam int Q_DEPTH        = 4;
  localparam int Q_AW           = $clog2(Q_DEPTH);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [2:0] CFG_ENABLED      = 3'd0;
  localparam logic [2:0] CFG_PITCH        = 3'd1;
  localparam logic [2:0] CFG_TEXT_COLUMNS = 3'd2;
  localparam logic [2:0] CFG_TEXT_ROWS    = 3'd3;
  localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_BPP          = 3'd5;
  localparam logic [2:0] CFG_SCREEN_LINES = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  char_code;
    logic [12:0] font_address;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] byte_offset;
    logic [7:0]  pixel_mask;
    logic [31:0] clear_bytes;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        enabled;
    logic [15:0] pitch_bytes;
    logic [10:0] text_columns;
    logic [10:0] text_rows;
    logic [5:0]  glyph_height;
    logic [3:0]  bytes_per_pixel;
    logic [13:0] screen_lines;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_GLYPH,
    OP_NEWLINE
  } op_t;

  // work descriptor handed from front end to back end
  typedef struct packed {
    op_t                 op;
    logic                clear;
    logic [7:0]          code;
    logic [12:0]         faddr;
    logic [7:0]          fbyte;
    logic [CURSOR_W-1:0] col;
    logic [CURSOR_W-1:0] row;
  } entry_t;

endpackage

@@ rtl/core/tcgr_front.sv @@
module tcgr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  tcgr_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcgr_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output tcgr_pkg::entry_t q_entry
);

  logic [tcgr_pkg::CURSOR_W-1:0] col_r, col_nxt;
  logic [tcgr_pkg::CURSOR_W-1:0] row_r, row_nxt;
  logic [tcgr_pkg::CURSOR_W:0]   ncol, nrow;
  logic                          clear;
  logic                          is_nl;

  assign in_ready = !q_full;
  // disabled console still takes transfers and drops them
  assign q_push   = in_valid && in_ready && cfg.enabled;
  assign is_nl    = (in_data.char_code == tcgr_pkg::NEWLINE_CODE);

  always_comb begin
    ncol = {1'b0, col_r} + (tcgr_pkg::CURSOR_W+1)'(1);
    nrow = {1'b0, row_r};
    if (is_nl) begin
      ncol = '0;
      nrow = {1'b0, row_r} + (tcgr_pkg::CURSOR_W+1)'(1);
    end else if (ncol >= cfg.text_columns ||
                 ncol >= (tcgr_pkg::CURSOR_W+1)'(tcgr_pkg::CURSOR_LIMIT)) begin
      ncol = '0;
      nrow = {1'b0, row_r} + (tcgr_pkg::CURSOR_W+1)'(1);
    end
    clear = (nrow >= cfg.text_rows) ||
            (nrow >= (tcgr_pkg::CURSOR_W+1)'(tcgr_pkg::CURSOR_LIMIT));
    if (clear) begin
      nrow = '0;
    end
  end

  always_comb begin
    q_entry.op    = (in_data.cmd == tcgr_pkg::CMD_LOAD) ? tcgr_pkg::OP_LOAD :
                    (is_nl ? tcgr_pkg::OP_NEWLINE : tcgr_pkg::OP_GLYPH);
    q_entry.clear = clear;
    q_entry.code  = in_data.char_code;
    q_entry.faddr = in_data.font_address;
    q_entry.fbyte = in_data.font_byte;
    q_entry.col   = col_r;
    q_entry.row   = row_r;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push && in_data.cmd == tcgr_pkg::CMD_WRITE) begin
      col_nxt = ncol[tcgr_pkg::CURSOR_W-1:0];
      row_nxt = nrow[tcgr_pkg::CURSOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ rtl/core/tcgr_fifo.sv @@
module tcgr_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tcgr_pkg::entry_t push_data,
  input  logic             pop,
  output tcgr_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  tcgr_pkg::entry_t          slots_r [tcgr_pkg::Q_DEPTH];
  logic [tcgr_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tcgr_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tcgr_pkg::Q_AW:0]   count_r, count_nxt;
  logic                      do_push, do_pop;

  assign full    = (count_r == (tcgr_pkg::Q_AW+1)'(tcgr_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + tcgr_pkg::Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + tcgr_pkg::Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (tcgr_pkg::Q_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (tcgr_pkg::Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/tcgr_back.sv @@
module tcgr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcgr_pkg::cfg_t      cfg,
  input  tcgr_pkg::entry_t    head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tcgr_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ROWS,
    S_CLR
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]                    code_r, code_nxt;
  logic [tcgr_pkg::CURSOR_W-1:0] col_r, col_nxt;
  logic [tcgr_pkg::CURSOR_W-1:0] row_r, row_nxt;
  logic                          clr_r, clr_nxt;
  logic [15:0]                   rowgh_r, rowgh_nxt;
  logic [16:0]                   xbytes_r, xbytes_nxt;
  logic [13:0]                   fidx_r, fidx_nxt;
  logic [31:0]                   off_r, off_nxt;
  logic [5:0]                    y_r, y_nxt;
  logic [5:0]                    nrows_r, nrows_nxt;

  // result waiting on the font read; mask joins it from mem_q_r
  logic        slot_v_r, slot_v_nxt;
  logic        slot_kind_r, slot_kind_nxt;
  logic [31:0] slot_off_r, slot_off_nxt;
  logic [31:0] slot_clr_r, slot_clr_nxt;
  logic        slot_last_r, slot_last_nxt;

  tcgr_pkg::out_item_t out_r, out_nxt;
  logic                out_v_r, out_v_nxt;

  logic [7:0]                    font_mem [tcgr_pkg::STORE_DEPTH];
  logic [7:0]                    mem_q_r;
  logic                          wr_en, rd_en;
  logic [tcgr_pkg::STORE_AW-1:0] rd_addr;

  logic move, slot_free, issue, last_row;

  assign move      = slot_v_r && (!out_v_r || out_ready);
  assign slot_free = !slot_v_r || move;
  assign issue     = slot_free && (state_r == S_ROWS || state_r == S_CLR);
  assign rd_en     = slot_free && (state_r == S_ROWS);
  assign rd_addr   = fidx_r[tcgr_pkg::STORE_AW-1:0] + tcgr_pkg::STORE_AW'(y_r);
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign wr_en     = q_pop && (head.op == tcgr_pkg::OP_LOAD);
  assign last_row  = (y_r == nrows_r - 6'd1);

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[head.faddr[tcgr_pkg::STORE_AW-1:0]] <= head.fbyte;
    end
    if (rd_en) begin
      mem_q_r <= font_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    clr_nxt       = clr_r;
    rowgh_nxt     = rowgh_r;
    xbytes_nxt    = xbytes_r;
    fidx_nxt      = fidx_r;
    off_nxt       = off_r;
    y_nxt         = y_r;
    nrows_nxt     = nrows_r;
    slot_kind_nxt = slot_kind_r;
    slot_off_nxt  = slot_off_r;
    slot_clr_nxt  = slot_clr_r;
    slot_last_nxt = slot_last_r;

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          code_nxt = head.code;
          col_nxt  = head.col;
          row_nxt  = head.row;
          clr_nxt  = head.clear;
          case (head.op)
            tcgr_pkg::OP_GLYPH:   state_nxt = S_MUL1;
            tcgr_pkg::OP_NEWLINE: state_nxt = head.clear ? S_CLR : S_IDLE;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL1: begin
        rowgh_nxt  = 16'({6'b0, row_r} * {10'b0, cfg.glyph_height});
        xbytes_nxt = 17'({7'b0, col_r} * {13'b0, cfg.bytes_per_pixel}) << 3;
        fidx_nxt   = 14'({6'b0, code_r} * {8'b0, cfg.glyph_height});
        nrows_nxt  = (cfg.glyph_height > 6'(tcgr_pkg::MAX_GLYPH_ROWS)) ?
                     6'(tcgr_pkg::MAX_GLYPH_ROWS) : cfg.glyph_height;
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        off_nxt = 32'({16'b0, rowgh_r} * {16'b0, cfg.pitch_bytes}) + {15'b0, xbytes_r};
        y_nxt   = '0;
        if (nrows_r == '0) begin
          state_nxt = clr_r ? S_CLR : S_IDLE;
        end else begin
          state_nxt = S_ROWS;
        end
      end
      S_ROWS: begin
        if (slot_free) begin
          slot_kind_nxt = tcgr_pkg::KIND_ROW;
          slot_off_nxt  = off_r;
          slot_clr_nxt  = '0;
          slot_last_nxt = last_row && !clr_r;
          off_nxt       = off_r + {16'b0, cfg.pitch_bytes};
          y_nxt         = y_r + 6'd1;
          if (last_row) begin
            state_nxt = clr_r ? S_CLR : S_IDLE;
          end
        end
      end
      S_CLR: begin
        if (slot_free) begin
          slot_kind_nxt = tcgr_pkg::KIND_CLEAR;
          slot_off_nxt  = '0;
          slot_clr_nxt  = 32'({16'b0, cfg.pitch_bytes} * {18'b0, cfg.screen_lines});
          slot_last_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    slot_v_nxt = slot_v_r;
    if (issue) begin
      slot_v_nxt = 1'b1;
    end else if (move) begin
      slot_v_nxt = 1'b0;
    end

    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (move) begin
      out_nxt.kind        = slot_kind_r;
      out_nxt.byte_offset = slot_off_r;
      out_nxt.pixel_mask  = (slot_kind_r == tcgr_pkg::KIND_ROW) ? mem_q_r : 8'd0;
      out_nxt.clear_bytes = slot_clr_r;
      out_nxt.last        = slot_last_r;
      out_v_nxt           = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      slot_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      slot_v_r <= slot_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    code_r      <= code_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    clr_r       <= clr_nxt;
    rowgh_r     <= rowgh_nxt;
    xbytes_r    <= xbytes_nxt;
    fidx_r      <= fidx_nxt;
    off_r       <= off_nxt;
    y_r         <= y_nxt;
    nrows_r     <= nrows_nxt;
    slot_kind_r <= slot_kind_nxt;
    slot_off_r  <= slot_off_nxt;
    slot_clr_r  <= slot_clr_nxt;
    slot_last_r <= slot_last_nxt;
    out_r       <= out_nxt;
  end

endmodule

@@ rtl/core/text_console_glyph_renderer_unit.sv @@
// Input side takes one transfer per cycle while the 4-deep work queue has room.
// Back end: a glyph item passes S_MUL1 and S_MUL2, then one font-store read per glyph
// row (min(glyph_height, 32) rows) on the single read port, waiting for a free slot.
// Newline and font load items finish in S_IDLE; a screen clear adds an S_CLR step.
// A row result goes from S_ROWS through the font read slot to the output register.
// Reset (rst_n low, synchronous): registers to defaults, cursor to 0; font store kept.
module text_console_glyph_renderer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcgr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcgr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  tcgr_pkg::cfg_t   cfg_r;
  tcgr_pkg::entry_t push_entry, head;
  logic             q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= 1'b0;
      cfg_r.pitch_bytes     <= 16'd4096;
      cfg_r.text_columns    <= 11'd128;
      cfg_r.text_rows       <= 11'd48;
      cfg_r.glyph_height    <= 6'd16;
      cfg_r.bytes_per_pixel <= 4'd4;
      cfg_r.screen_lines    <= 14'd768;
    end else if (cfg_we) begin
      case (cfg_index)
        tcgr_pkg::CFG_ENABLED:      cfg_r.enabled         <= cfg_wdata[0];
        tcgr_pkg::CFG_PITCH:        cfg_r.pitch_bytes     <= cfg_wdata;
        tcgr_pkg::CFG_TEXT_COLUMNS: cfg_r.text_columns    <= cfg_wdata[10:0];
        tcgr_pkg::CFG_TEXT_ROWS:    cfg_r.text_rows       <= cfg_wdata[10:0];
        tcgr_pkg::CFG_GLYPH_HEIGHT: cfg_r.glyph_height    <= cfg_wdata[5:0];
        tcgr_pkg::CFG_BPP:          cfg_r.bytes_per_pixel <= cfg_wdata[3:0];
        tcgr_pkg::CFG_SCREEN_LINES: cfg_r.screen_lines    <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  tcgr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  tcgr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tcgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
